@@ sv/sm3_pkg.sv @@
// Shared types, constants and functions of the SM3 hash engine.
package sm3_pkg;

  typedef logic [7:0][31:0]  cv_t;
  typedef logic [15:0][31:0] blk_t;

  // One classified input item: payload word already masked and, if partial, padded.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nvalid;
    logic        last;
  } item_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } comp_ctl_t;

  localparam logic [31:0] T_LOW   = 32'h79cc4519;
  localparam logic [31:0] T_HIGH  = 32'h7a879d8a;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  localparam cv_t IV = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

@@ sv/sm3_if.sv @@
// Valid/ready channel interfaces for message words and digest words.
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ sv/sm3_front.sv @@
// Input front end: classifies message words and queues them for the back end.
module sm3_front (
  input  logic               clk,
  input  logic               rst_n,
  sm3_in_if.sink             in_ch,
  output logic               q_valid,
  input  logic               q_ready,
  output sm3_pkg::item_t     q_item
);

  sm3_pkg::item_t item_c;
  sm3_pkg::item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic [2:0] nv;
  logic       push, pop;

  // A final word keeps only its valid bytes; with fewer than four it receives the 0x80 marker after them.
  always_comb begin
    nv = in_ch.end_of_message ?
         ((in_ch.valid_bytes > sm3_pkg::FULL_BYTES) ? sm3_pkg::FULL_BYTES : in_ch.valid_bytes)
         : sm3_pkg::FULL_BYTES;
    item_c.nvalid = nv;
    item_c.last   = in_ch.end_of_message;
    item_c.word   = in_ch.message_word;
    case (nv)
      3'd0: item_c.word = {sm3_pkg::PAD_BYTE, 24'h0};
      3'd1: item_c.word = {in_ch.message_word[31:24], sm3_pkg::PAD_BYTE, 16'h0};
      3'd2: item_c.word = {in_ch.message_word[31:16], sm3_pkg::PAD_BYTE, 8'h0};
      3'd3: item_c.word = {in_ch.message_word[31:8], sm3_pkg::PAD_BYTE};
      default: item_c.word = in_ch.message_word;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item_c;
  end

endmodule

@@ sv/sm3_comp.sv @@
// SM3 compression unit: one round per cycle with on-the-fly message expansion.
module sm3_comp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sm3_pkg::comp_ctl_t   ctl,
  input  sm3_pkg::blk_t        blk,
  output logic                 done,
  output sm3_pkg::cv_t         cv
);

  sm3_pkg::cv_t  cv_r, v_r, v_nxt;
  sm3_pkg::blk_t win_r;
  logic [5:0]    j_r;
  logic          run_r, done_r;
  logic [31:0]   a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;

  assign cv   = cv_r;
  assign done = done_r;

  always_comb begin
    tj  = (j_r < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rol(v_r[0], 5'd12);
    ss1 = sm3_pkg::rol(a12 + v_r[4] + sm3_pkg::rol(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1 = ff + v_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + v_r[7] + ss1 + win_r[0];
    v_nxt[0] = tt1;
    v_nxt[1] = v_r[0];
    v_nxt[2] = sm3_pkg::rol(v_r[1], 5'd9);
    v_nxt[3] = v_r[2];
    v_nxt[4] = sm3_pkg::p0(tt2);
    v_nxt[5] = v_r[4];
    v_nxt[6] = sm3_pkg::rol(v_r[5], 5'd19);
    v_nxt[7] = v_r[6];
    wnew = sm3_pkg::p1(win_r[0] ^ win_r[7] ^ sm3_pkg::rol(win_r[13], 5'd15))
           ^ sm3_pkg::rol(win_r[3], 5'd7) ^ win_r[10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      j_r    <= 6'd0;
      cv_r   <= sm3_pkg::IV;
    end else begin
      done_r <= 1'b0;
      if (ctl.reinit) cv_r <= sm3_pkg::IV;
      if (ctl.start) begin
        run_r <= 1'b1;
        j_r   <= 6'd0;
        v_r   <= cv_r;
        win_r <= blk;
      end else if (run_r) begin
        v_r   <= v_nxt;
        win_r <= {wnew, win_r[15:1]};
        j_r   <= j_r + 6'd1;
        if (j_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          cv_r   <= cv_r ^ v_nxt;
        end
      end
    end
  end

endmodule

@@ sv/sm3_back.sv @@
// Back end: block assembly, padding sequencer and digest output.
module sm3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sm3_pkg::item_t     q_item,
  sm3_out_if.source          out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COMP = 4'b0010,
    S_PAD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t             state_r;
  sm3_pkg::blk_t      blk_r;
  logic [60:0]        cnt_r;
  logic [3:0]         p_r, wi;
  logic               need80_r, lenok_r, final_r, ret_pad_r, start_r;
  logic [2:0]         k_r;
  logic [63:0]        bitlen;
  logic               comp_done;
  sm3_pkg::comp_ctl_t ctl;
  sm3_pkg::cv_t       cv;

  assign wi      = cnt_r[5:2];
  assign bitlen  = {cnt_r, 3'b000};
  assign q_ready = (state_r == S_IDLE);
  assign ctl.start  = start_r;
  assign ctl.reinit = (state_r == S_OUT) && out_ch.ready && (k_r == 3'd7);

  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = cv[k_r];
  assign out_ch.word_index  = k_r;
  assign out_ch.last_word   = (k_r == 3'd7);

  sm3_comp u_comp (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .blk  (blk_r),
    .done (comp_done),
    .cv   (cv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= 61'd0;
      start_r   <= 1'b0;
      k_r       <= 3'd0;
      final_r   <= 1'b0;
      need80_r  <= 1'b0;
      lenok_r   <= 1'b0;
      ret_pad_r <= 1'b0;
      p_r       <= 4'd0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            blk_r[wi] <= q_item.word;
            final_r   <= 1'b0;
            if (!q_item.last) begin
              cnt_r <= cnt_r + 61'd4;
              if (wi == 4'd15) begin
                start_r   <= 1'b1;
                ret_pad_r <= 1'b0;
                state_r   <= S_COMP;
              end
            end else begin
              cnt_r    <= cnt_r + {58'd0, q_item.nvalid};
              need80_r <= (q_item.nvalid == sm3_pkg::FULL_BYTES);
              lenok_r  <= (q_item.nvalid == sm3_pkg::FULL_BYTES) ? (wi <= 4'd12)
                                                                : (wi <= 4'd13);
              p_r      <= wi + 4'd1;
              if (wi == 4'd15) begin
                start_r   <= 1'b1;
                ret_pad_r <= 1'b1;
                state_r   <= S_COMP;
              end else begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          if (need80_r) begin
            blk_r[p_r] <= sm3_pkg::PAD_WORD;
            need80_r   <= 1'b0;
            lenok_r    <= (p_r <= 4'd13);
          end else if (lenok_r && p_r == 4'd14) begin
            blk_r[p_r] <= bitlen[63:32];
          end else if (lenok_r && p_r == 4'd15) begin
            blk_r[p_r] <= bitlen[31:0];
            final_r    <= 1'b1;
          end else begin
            blk_r[p_r] <= 32'd0;
          end
          p_r <= p_r + 4'd1;
          if (p_r == 4'd15) begin
            start_r   <= 1'b1;
            ret_pad_r <= 1'b1;
            state_r   <= S_COMP;
          end
        end
        S_COMP: begin
          if (comp_done) begin
            if (final_r) begin
              k_r     <= 3'd0;
              state_r <= S_OUT;
            end else if (ret_pad_r) begin
              lenok_r <= 1'b1;
              state_r <= S_PAD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            k_r <= k_r + 3'd1;
            if (k_r == 3'd7) begin
              cnt_r   <= 61'd0;
              final_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/sm3_hash_engine.sv @@
// Top level of the streaming SM3 hash engine.
// A message word is taken from a two-entry queue while the back end is idle; each sixteenth
// word starts a 64-round compression, one round per cycle, and no word is taken until
// it ends. The final word adds padding words and one or two compressions, then
// eight digest words leave one per cycle while the sink is ready.
// Synchronous active-low reset loads the initial chaining value and clears the count.
module sm3_hash_engine (
  input  logic      clk,
  input  logic      rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  logic           q_valid, q_ready;
  sm3_pkg::item_t q_item;

  sm3_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item (q_item)
  );

  sm3_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item (q_item),
    .out_ch (out_ch)
  );

endmodule
